FILE: rtl/core/hbridge_ramped_pwm_drive_macros.svh
// Assertion macros shared by the H-bridge drive RTL.
`ifndef HBRIDGE_RAMPED_PWM_DRIVE_MACROS_SVH
`define HBRIDGE_RAMPED_PWM_DRIVE_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define HRPD_ASSERT_NOW(LABEL, CLK, RSTN, ANTE, CONS, MSG) \
  LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
    else $error(MSG);

// Check a consequence in the cycle after its cause.
`define HRPD_ASSERT_NEXT(LABEL, CLK, RSTN, ANTE, CONS, MSG) \
  LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
    else $error(MSG);

`endif

FILE: rtl/core/hrpd_pkg.sv
// Shared types and constants of the H-bridge ramped PWM drive.
`default_nettype none

package hrpd_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_INPUT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_INPUT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL_WIDTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_PWM    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PWM       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_TIME     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL_BRAKE = 3'd7;

  // Register reset values
  localparam logic [15:0] RST_MIN_INPUT     = 16'd0;
  localparam logic [15:0] RST_MAX_INPUT     = 16'd1023;
  localparam logic [14:0] RST_NEUTRAL_WIDTH = 15'd20;
  localparam logic        RST_INVERT        = 1'b0;
  localparam logic        RST_DOUBLE_PWM    = 1'b1;
  localparam logic [7:0]  RST_MAX_PWM       = 8'd255;
  localparam logic [15:0] RST_RAMP_TIME     = 16'd0;
  localparam logic        RST_NEUTRAL_BRAKE = 1'b0;

  // Ramp start: middle of the neutral band of the reset registers
  localparam logic [15:0] RAMP_RESET = 16'd511;

  // Pin levels
  localparam logic [7:0] PIN_HIGH = 8'd255;
  localparam logic [7:0] PIN_LOW  = 8'd0;

  // Duty divider: one quotient bit per step
  localparam int DIV_STEPS = 8;
  localparam int DIV_CNT_W = 3;
  localparam logic [DIV_CNT_W-1:0] DIV_CNT_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  typedef struct packed {
    logic [15:0] min_input;
    logic [15:0] max_input;
    logic [14:0] neutral_width;
    logic        invert;
    logic        double_pwm;
    logic [7:0]  max_pwm;
    logic [15:0] ramp_time;
    logic        neutral_brake;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic step;
    logic classify;
    logic mult;
    logic div_step;
    logic finish;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/hrpd_in_if.sv
// Command channel: valid/ready with command, brake flag and time stamp.
`default_nettype none

interface hrpd_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] command_value;
  logic               brake_mode;
  logic        [31:0] now_ms;

  modport source (output valid, output command_value, output brake_mode, output now_ms,
                  input ready);
  modport sink (input valid, input command_value, input brake_mode, input now_ms,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/core/hrpd_out_if.sv
// Result channel: valid/ready with pin duty levels and ramp value.
`default_nettype none

interface hrpd_out_if;
  logic               valid;
  logic               ready;
  logic        [7:0]  pin1_level;
  logic        [7:0]  pin2_level;
  logic signed [15:0] ramp_value;

  modport source (output valid, output pin1_level, output pin2_level, output ramp_value,
                  input ready);
  modport sink (input valid, input pin1_level, input pin2_level, input ramp_value,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/core/hrpd_cfg_regs.sv
// Configuration register file of the H-bridge drive.
`default_nettype none

module hrpd_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [hrpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hrpd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output hrpd_pkg::cfg_t                  cfg
);

  hrpd_pkg::cfg_t cfg_r;
  hrpd_pkg::cfg_t cfg_nxt;

  // Decode the write into the addressed field
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        hrpd_pkg::REG_MIN_INPUT:     cfg_nxt.min_input     = cfg_wdata;
        hrpd_pkg::REG_MAX_INPUT:     cfg_nxt.max_input     = cfg_wdata;
        hrpd_pkg::REG_NEUTRAL_WIDTH: cfg_nxt.neutral_width = cfg_wdata[14:0];
        hrpd_pkg::REG_INVERT:        cfg_nxt.invert        = cfg_wdata[0];
        hrpd_pkg::REG_DOUBLE_PWM:    cfg_nxt.double_pwm    = cfg_wdata[0];
        hrpd_pkg::REG_MAX_PWM:       cfg_nxt.max_pwm       = cfg_wdata[7:0];
        hrpd_pkg::REG_RAMP_TIME:     cfg_nxt.ramp_time     = cfg_wdata;
        hrpd_pkg::REG_NEUTRAL_BRAKE: cfg_nxt.neutral_brake = cfg_wdata[0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  // Hold the registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_input     <= hrpd_pkg::RST_MIN_INPUT;
      cfg_r.max_input     <= hrpd_pkg::RST_MAX_INPUT;
      cfg_r.neutral_width <= hrpd_pkg::RST_NEUTRAL_WIDTH;
      cfg_r.invert        <= hrpd_pkg::RST_INVERT;
      cfg_r.double_pwm    <= hrpd_pkg::RST_DOUBLE_PWM;
      cfg_r.max_pwm       <= hrpd_pkg::RST_MAX_PWM;
      cfg_r.ramp_time     <= hrpd_pkg::RST_RAMP_TIME;
      cfg_r.neutral_brake <= hrpd_pkg::RST_NEUTRAL_BRAKE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

FILE: rtl/core/hrpd_ctrl.sv
// Sequencing controller of the H-bridge drive.
`default_nettype none
`include "hbridge_ramped_pwm_drive_macros.svh"

module hrpd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hrpd_pkg::dp_stat_t  stat,
  output hrpd_pkg::dp_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_CLASS,
    S_MULT,
    S_DIV,
    S_DONE
  } state_t;

  state_t                         state_r, state_nxt;
  logic [hrpd_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = S_CLASS;
      end
      S_CLASS: begin
        cmd.classify = 1'b1;
        state_nxt    = S_MULT;
      end
      S_MULT: begin
        cmd.mult  = 1'b1;
        cnt_nxt   = hrpd_pkg::DIV_CNT_LAST;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // Wait until the output register can take the result
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  `HRPD_ASSERT_NOW(a_cmd_onehot, clk, rst_n, 1'b1, $onehot0(cmd), "two datapath commands at once")
  `HRPD_ASSERT_NEXT(a_busy_after_load, clk, rst_n, cmd.load, !in_ready, "ready while busy")
  `HRPD_ASSERT_NEXT(a_div_count, clk, rst_n, cmd.mult, cnt_r == hrpd_pkg::DIV_CNT_LAST, "bad div count")

endmodule

`default_nettype wire

FILE: rtl/core/hrpd_datapath.sv
// Ramp, deadband, duty scaling and output register of the H-bridge drive.
`default_nettype none
`include "hbridge_ramped_pwm_drive_macros.svh"

module hrpd_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  hrpd_pkg::cfg_t     cfg,
  input  hrpd_pkg::dp_cmd_t  cmd,
  output hrpd_pkg::dp_stat_t stat,
  input  logic signed [15:0] cmd_value,
  input  logic               cmd_brake,
  input  logic        [31:0] cmd_now_ms,
  input  logic               out_ready,
  output logic               out_valid,
  output logic        [7:0]  out_pin1,
  output logic        [7:0]  out_pin2,
  output logic signed [15:0] out_ramp
);

  typedef enum logic [1:0] {
    DIR_NEUTRAL,
    DIR_FWD,
    DIR_REV
  } dir_t;

  // State and working registers
  logic signed [15:0] ramp_r;
  logic        [31:0] last_r;
  logic signed [17:0] cmd_eff_r;
  logic               step_ok_r;
  logic               brake_r;
  logic signed [17:0] lo_r, hi_r;
  dir_t               dir_r;
  logic        [16:0] dist_r;
  logic signed [17:0] span_r;
  logic               sat_r;
  logic        [24:0] rem_r;
  logic        [23:0] dvs_r;
  logic        [hrpd_pkg::DIV_STEPS-1:0] quot_r;
  logic               out_valid_r;
  logic        [7:0]  pin1_r, pin2_r;
  logic signed [15:0] ramp_out_r;

  logic signed [17:0] min_ext, max_ext, ramp_ext;
  logic signed [16:0] lim_sum;
  logic        [16:0] sum_rnd;
  logic signed [15:0] centre;
  logic signed [17:0] half;
  logic signed [17:0] cmd_ext, cmd_inv;
  logic        [31:0] elapsed;
  logic               ramp_inc, ramp_dec;
  logic signed [17:0] ramp_nxt_ext;
  logic signed [15:0] ramp_nxt;
  logic               is_fwd, is_rev;
  logic signed [17:0] dist_fwd, dist_rev, span_fwd, span_rev;
  logic        [24:0] prod;
  logic               rem_ge;
  logic        [7:0]  duty;
  logic        [7:0]  pin1_nxt, pin2_nxt;

  assign min_ext  = {{2{cfg.min_input[15]}}, $signed(cfg.min_input)};
  assign max_ext  = {{2{cfg.max_input[15]}}, $signed(cfg.max_input)};
  assign ramp_ext = {{2{ramp_r[15]}}, ramp_r};

  // Mirror the command and test the step interval
  assign lim_sum = $signed({cfg.min_input[15], cfg.min_input})
                 + $signed({cfg.max_input[15], cfg.max_input});
  assign cmd_ext = {{2{cmd_value[15]}}, cmd_value};
  assign cmd_inv = {lim_sum[16], lim_sum} - cmd_ext;
  assign elapsed = cmd_now_ms - last_r;

  // Neutral band: centre rounds toward zero
  assign sum_rnd = lim_sum + {16'd0, lim_sum[16]};
  assign centre  = $signed(sum_rnd[16:1]);
  assign half    = $signed({4'd0, cfg.neutral_width[14:1]});

  // Move the ramp one count toward the command
  assign ramp_inc = step_ok_r && (cmd_eff_r > ramp_ext)
                    && (ramp_r < $signed(cfg.max_input));
  assign ramp_dec = step_ok_r && (cmd_eff_r < ramp_ext)
                    && (ramp_r > $signed(cfg.min_input));
  always_comb begin
    ramp_nxt_ext = ramp_ext;
    if (ramp_inc) begin
      ramp_nxt_ext = ramp_ext + 18'sd1;
    end else if (ramp_dec) begin
      ramp_nxt_ext = ramp_ext - 18'sd1;
    end
  end
  assign ramp_nxt = ramp_nxt_ext[15:0];

  // Distance into the band edge and span to the range end
  assign is_fwd   = (ramp_ext >= hi_r);
  assign is_rev   = (ramp_ext <= lo_r);
  assign dist_fwd = ramp_ext - hi_r;
  assign span_fwd = max_ext - hi_r;
  assign dist_rev = lo_r - ramp_ext;
  assign span_rev = lo_r - min_ext;

  assign prod = 25'(dist_r) * 25'(cfg.max_pwm);

  // Restoring divider compare
  assign rem_ge = (rem_r >= {1'b0, dvs_r});

  // Pin levels from direction and mode
  assign duty = sat_r ? cfg.max_pwm : quot_r;
  always_comb begin
    pin1_nxt = hrpd_pkg::PIN_LOW;
    pin2_nxt = hrpd_pkg::PIN_LOW;
    case (dir_r)
      DIR_FWD: begin
        if (cfg.double_pwm && !brake_r) begin
          pin1_nxt = hrpd_pkg::PIN_LOW;
          pin2_nxt = duty;
        end else begin
          pin1_nxt = hrpd_pkg::PIN_HIGH - duty;
          pin2_nxt = hrpd_pkg::PIN_HIGH;
        end
      end
      DIR_REV: begin
        if (cfg.double_pwm && brake_r) begin
          pin1_nxt = hrpd_pkg::PIN_HIGH;
          pin2_nxt = hrpd_pkg::PIN_HIGH - duty;
        end else begin
          pin1_nxt = duty;
          pin2_nxt = hrpd_pkg::PIN_LOW;
        end
      end
      default: begin
        if (!cfg.double_pwm || (brake_r && cfg.neutral_brake)) begin
          pin1_nxt = hrpd_pkg::PIN_HIGH;
          pin2_nxt = hrpd_pkg::PIN_HIGH;
        end
      end
    endcase
  end

  // Ramp state, time stamp and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_r      <= $signed(hrpd_pkg::RAMP_RESET);
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load && (elapsed >= {16'd0, cfg.ramp_time})) begin
        last_r <= cmd_now_ms;
      end
      if (cmd.step) begin
        ramp_r <= ramp_nxt;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers of one transaction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_eff_r <= cfg.invert ? cmd_inv : cmd_ext;
      step_ok_r <= (elapsed >= {16'd0, cfg.ramp_time});
      brake_r   <= cmd_brake;
    end
    if (cmd.step) begin
      lo_r <= {{2{centre[15]}}, centre} - half;
      hi_r <= {{2{centre[15]}}, centre} + half;
    end
    if (cmd.classify) begin
      if (is_fwd) begin
        dir_r  <= DIR_FWD;
        dist_r <= dist_fwd[16:0];
        span_r <= span_fwd;
      end else if (is_rev) begin
        dir_r  <= DIR_REV;
        dist_r <= dist_rev[16:0];
        span_r <= span_rev;
      end else begin
        dir_r  <= DIR_NEUTRAL;
        dist_r <= '0;
        span_r <= '0;
      end
    end
    if (cmd.mult) begin
      sat_r  <= (span_r <= 18'sd0) || ($signed({1'b0, dist_r}) >= span_r);
      rem_r  <= prod;
      dvs_r  <= {span_r[16:0], 7'd0};
      quot_r <= '0;
    end
    if (cmd.div_step) begin
      if (rem_ge) begin
        rem_r <= rem_r - {1'b0, dvs_r};
      end
      quot_r <= {quot_r[hrpd_pkg::DIV_STEPS-2:0], rem_ge};
      dvs_r  <= dvs_r >> 1;
    end
    if (cmd.finish) begin
      pin1_r     <= pin1_nxt;
      pin2_r     <= pin2_nxt;
      ramp_out_r <= ramp_r;
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_pin1      = pin1_r;
  assign out_pin2      = pin2_r;
  assign out_ramp      = ramp_out_r;

  `HRPD_ASSERT_NOW(a_no_overwrite, clk, rst_n, cmd.finish, !out_valid_r || out_ready, "result lost")
  `HRPD_ASSERT_NEXT(a_ramp_hold, clk, rst_n, !cmd.step, $stable(ramp_r), "ramp moved off step")
  `HRPD_ASSERT_NOW(a_quot_bound, clk, rst_n, cmd.finish && !sat_r, quot_r <= cfg.max_pwm, "duty range")

endmodule

`default_nettype wire

FILE: rtl/core/hbridge_ramped_pwm_drive.sv
// Top level of the ramped H-bridge PWM drive.
`default_nettype none

// Each command transaction passes through acceptance, which loads it, ramp step, band
// classification, duty multiply, the restoring divider that forms one duty bit per cycle,
// and the write of the result into the output register. A finished result waits in the
// output register while the next command transaction is accepted and worked on; the block
// stalls only if that result is still untaken when the next one is ready. Configuration
// writes take effect at once and are meant for idle periods; there is no clearing pass
// after reset.
module hbridge_ramped_pwm_drive (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [hrpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hrpd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  hrpd_in_if.sink                         in_chan,
  hrpd_out_if.source                      out_chan
);

  hrpd_pkg::cfg_t     cfg;
  hrpd_pkg::dp_cmd_t  dp_cmd;
  hrpd_pkg::dp_stat_t dp_stat;
  logic               in_ready;

  // Configuration registers
  hrpd_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Sequencer
  hrpd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  // Ramp and duty datapath
  hrpd_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd        (dp_cmd),
    .stat       (dp_stat),
    .cmd_value  (in_chan.command_value),
    .cmd_brake  (in_chan.brake_mode),
    .cmd_now_ms (in_chan.now_ms),
    .out_ready  (out_chan.ready),
    .out_valid  (out_chan.valid),
    .out_pin1   (out_chan.pin1_level),
    .out_pin2   (out_chan.pin2_level),
    .out_ramp   (out_chan.ramp_value)
  );

  assign in_chan.ready = in_ready;

endmodule

`default_nettype wire
